### src/sgm_pkg.sv
// Shared constants for the sequence gap monitor.
`timescale 1ns / 1ps
`default_nettype none

package sgm_pkg;

    // Fixed field widths
    localparam int OP_BITS    = 2;
    localparam int FRAME_BITS = 32;
    localparam int IDX_BITS   = 5;
    localparam int STAT_BITS  = 64;
    localparam int SEQ_BITS   = 31;

    // Default counter width
    localparam int COUNT_BITS_DEF = 64;

    // Histogram memory geometry
    localparam int NUM_BINS = 9;
    localparam int BIN_BITS = 4;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_REQUEST = 2'd0;
    localparam logic [OP_BITS-1:0] OP_READY   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_READ    = 2'd2;

    // Statistic indexes
    localparam logic [IDX_BITS-1:0] STAT_REQUEST   = 5'd0;
    localparam logic [IDX_BITS-1:0] STAT_READY     = 5'd1;
    localparam logic [IDX_BITS-1:0] STAT_SEEN      = 5'd2;
    localparam logic [IDX_BITS-1:0] STAT_FIRST     = 5'd3;
    localparam logic [IDX_BITS-1:0] STAT_LAST      = 5'd4;
    localparam logic [IDX_BITS-1:0] STAT_STEP      = 5'd5;
    localparam logic [IDX_BITS-1:0] STAT_DUP       = 5'd6;
    localparam logic [IDX_BITS-1:0] STAT_BACK_JUMP = 5'd7;
    localparam logic [IDX_BITS-1:0] STAT_FWD_JUMP  = 5'd8;
    localparam logic [IDX_BITS-1:0] STAT_DISORDER  = 5'd9;
    localparam logic [IDX_BITS-1:0] STAT_MAX_FWD   = 5'd10;
    localparam logic [IDX_BITS-1:0] STAT_MAX_BACK  = 5'd11;
    localparam logic [IDX_BITS-1:0] STAT_HIST_BASE = 5'd12;
    localparam logic [IDX_BITS-1:0] STAT_HIST_LAST = 5'd20;

    // Histogram bin codes
    localparam logic [BIN_BITS-1:0] BIN_SAME      = 4'd0;
    localparam logic [BIN_BITS-1:0] BIN_BACK_BASE = 4'd4;
    localparam logic [BIN_BITS-1:0] BIN_LAST      = 4'd8;

    // Gap magnitude class limits
    localparam logic [SEQ_BITS-1:0] GAP_ONE   = 31'd1;
    localparam logic [SEQ_BITS-1:0] GAP_SMALL = 31'd5;
    localparam logic [SEQ_BITS-1:0] GAP_MID   = 31'd30;

    // Bin offset (1..4) for a nonzero gap magnitude
    function automatic logic [BIN_BITS-1:0] gap_class(input logic [SEQ_BITS-1:0] mag);
        logic [BIN_BITS-1:0] cls;
        if (mag == GAP_ONE) begin
            cls = 4'd1;
        end else if (mag <= GAP_SMALL) begin
            cls = 4'd2;
        end else if (mag <= GAP_MID) begin
            cls = 4'd3;
        end else begin
            cls = 4'd4;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

### src/sequence_gap_monitor.sv
// Sequence gap monitor: order statistics over a stream of sequence numbers.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake                  | Words
// ---------+-----+----------------------------+-------------------------------------
// input    | in  | i_in_valid / o_in_stall    | operation, frame_number, stat_index
// output   | out | o_out_valid / i_out_stall  | stat_value (reads only)
//
// One word per cycle. Scalar counters update at the accept edge; the gap
// histogram lives in a 9-entry memory with a registered read, so a bin is read
// at accept and written back in the following cycle, with a write-to-read bypass.
// A read word returns its statistic through the stage 1 and output registers.
// Reset (synchronous, active low) clears all scalar counters and the bin valid bits.
// Input stalls only while a read result is waiting and the output is stalled.
module sequence_gap_monitor #(
    parameter int COUNT_BITS = sgm_pkg::COUNT_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire  [sgm_pkg::OP_BITS-1:0]           i_operation,
    input  wire  signed [sgm_pkg::FRAME_BITS-1:0] i_frame_number,
    input  wire  [sgm_pkg::IDX_BITS-1:0]          i_stat_index,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic [sgm_pkg::STAT_BITS-1:0]         o_stat_value
);

    localparam int SB = sgm_pkg::SEQ_BITS;
    localparam int BB = sgm_pkg::BIN_BITS;

    typedef logic [COUNT_BITS-1:0] t_count;

    // Saturating increment
    function automatic t_count bump(input t_count c);
        return (c == '1) ? c : c + t_count'(1);
    endfunction

    // Scalar state
    t_count        r_request_count, r_ready_count, r_step_count, r_dup_count;
    t_count        r_back_jump_count, r_fwd_jump_count, r_disorder_count;
    logic          r_seen_any;
    logic [SB-1:0] r_first_seq, r_prev_seq, r_largest_fwd_gap, r_largest_back_gap;

    // Histogram memory and its valid bits
    t_count                        r_hist_mem [sgm_pkg::NUM_BINS];
    logic [sgm_pkg::NUM_BINS-1:0]  r_bin_valid;

    // Stage 1 registers
    logic          r_s1_valid, r_s1_read, r_s1_hist, r_s1_bump;
    logic [BB-1:0] r_s1_addr;
    logic [sgm_pkg::STAT_BITS-1:0] r_s1_scalar;
    t_count        r_rd_data;
    logic          r_rd_valid;

    // Output register
    logic                          r_out_valid;
    logic [sgm_pkg::STAT_BITS-1:0] r_out_value;

    // Handshake
    logic s1_hold, accept;
    assign s1_hold    = r_s1_valid && r_s1_read && r_out_valid && i_out_stall;
    assign o_in_stall = s1_hold;
    assign accept     = i_in_valid && !s1_hold;

    // Request decode and gap classification
    logic          is_req, is_ready, is_read;
    logic [SB-1:0] seq, fwd_mag, back_mag;
    logic          seq_gt, seq_eq;
    logic [BB-1:0] req_bin;
    assign is_req   = accept && (i_operation == sgm_pkg::OP_REQUEST) && !i_frame_number[31];
    assign is_ready = accept && (i_operation == sgm_pkg::OP_READY);
    assign is_read  = accept && (i_operation == sgm_pkg::OP_READ);
    assign seq      = i_frame_number[SB-1:0];
    assign fwd_mag  = seq - r_prev_seq;
    assign back_mag = r_prev_seq - seq;
    assign seq_gt   = seq > r_prev_seq;
    assign seq_eq   = seq == r_prev_seq;

    always_comb begin
        priority if (seq_eq) begin
            req_bin = sgm_pkg::BIN_SAME;
        end else if (seq_gt) begin
            req_bin = sgm_pkg::gap_class(fwd_mag);
        end else begin
            req_bin = sgm_pkg::BIN_BACK_BASE + sgm_pkg::gap_class(back_mag);
        end
    end

    // Histogram read address for a read word
    logic [sgm_pkg::IDX_BITS-1:0] idx_off;
    logic                         idx_hist;
    assign idx_off  = i_stat_index - sgm_pkg::STAT_HIST_BASE;
    assign idx_hist = (i_stat_index >= sgm_pkg::STAT_HIST_BASE)
                   && (i_stat_index <= sgm_pkg::STAT_HIST_LAST);

    logic          hist_rd_en, hist_bump;
    logic [BB-1:0] rd_addr;
    assign hist_bump  = is_req && r_seen_any;
    assign hist_rd_en = hist_bump || (is_read && idx_hist);
    assign rd_addr    = hist_bump ? req_bin : idx_off[BB-1:0];

    // Scalar read mux (state before this word)
    logic [sgm_pkg::STAT_BITS-1:0] scalar_val;
    always_comb begin
        unique case (i_stat_index)
            sgm_pkg::STAT_REQUEST:   scalar_val = sgm_pkg::STAT_BITS'(r_request_count);
            sgm_pkg::STAT_READY:     scalar_val = sgm_pkg::STAT_BITS'(r_ready_count);
            sgm_pkg::STAT_SEEN:      scalar_val = sgm_pkg::STAT_BITS'(r_seen_any);
            sgm_pkg::STAT_FIRST:     scalar_val = sgm_pkg::STAT_BITS'(r_first_seq);
            sgm_pkg::STAT_LAST:      scalar_val = sgm_pkg::STAT_BITS'(r_prev_seq);
            sgm_pkg::STAT_STEP:      scalar_val = sgm_pkg::STAT_BITS'(r_step_count);
            sgm_pkg::STAT_DUP:       scalar_val = sgm_pkg::STAT_BITS'(r_dup_count);
            sgm_pkg::STAT_BACK_JUMP: scalar_val = sgm_pkg::STAT_BITS'(r_back_jump_count);
            sgm_pkg::STAT_FWD_JUMP:  scalar_val = sgm_pkg::STAT_BITS'(r_fwd_jump_count);
            sgm_pkg::STAT_DISORDER:  scalar_val = sgm_pkg::STAT_BITS'(r_disorder_count);
            sgm_pkg::STAT_MAX_FWD:   scalar_val = sgm_pkg::STAT_BITS'(r_largest_fwd_gap);
            sgm_pkg::STAT_MAX_BACK:  scalar_val = sgm_pkg::STAT_BITS'(r_largest_back_gap);
            default:                 scalar_val = '0;
        endcase
    end

    // Scalar counters, updated at accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_request_count    <= '0;
            r_ready_count      <= '0;
            r_step_count       <= '0;
            r_dup_count        <= '0;
            r_back_jump_count  <= '0;
            r_fwd_jump_count   <= '0;
            r_disorder_count   <= '0;
            r_seen_any         <= 1'b0;
            r_first_seq        <= '0;
            r_prev_seq         <= '0;
            r_largest_fwd_gap  <= '0;
            r_largest_back_gap <= '0;
        end else begin
            if (is_ready) begin
                r_ready_count <= bump(r_ready_count);
            end
            if (is_req) begin
                r_request_count <= bump(r_request_count);
                r_prev_seq      <= seq;
                if (!r_seen_any) begin
                    r_seen_any  <= 1'b1;
                    r_first_seq <= seq;
                end else if (seq_eq) begin
                    r_dup_count <= bump(r_dup_count);
                end else if (seq_gt) begin
                    if (fwd_mag == sgm_pkg::GAP_ONE) begin
                        r_step_count <= bump(r_step_count);
                    end else begin
                        r_fwd_jump_count <= bump(r_fwd_jump_count);
                    end
                    if (fwd_mag > r_largest_fwd_gap) begin
                        r_largest_fwd_gap <= fwd_mag;
                    end
                end else begin
                    r_back_jump_count <= bump(r_back_jump_count);
                    r_disorder_count  <= bump(r_disorder_count);
                    if (back_mag > r_largest_back_gap) begin
                        r_largest_back_gap <= back_mag;
                    end
                end
            end
        end
    end

    // Histogram write-back from stage 1
    logic   wr_en;
    t_count cur_bin, wr_data;
    assign cur_bin = r_rd_valid ? r_rd_data : '0;
    assign wr_data = bump(cur_bin);
    assign wr_en   = r_s1_valid && r_s1_bump;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist_mem[r_s1_addr] <= wr_data;
        end
    end

    // Histogram read with bypass of a same-cycle write
    always_ff @(posedge i_clk) begin
        if (hist_rd_en) begin
            if (wr_en && (r_s1_addr == rd_addr)) begin
                r_rd_data <= wr_data;
            end else begin
                r_rd_data <= r_hist_mem[rd_addr];
            end
        end
    end

    // Bin valid bits, read alongside the memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_bin_valid[r_s1_addr] <= 1'b1;
            end
            if (hist_rd_en) begin
                r_rd_valid <= r_bin_valid[rd_addr] || (wr_en && (r_s1_addr == rd_addr));
            end
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!s1_hold) begin
            r_s1_valid <= hist_bump || is_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s1_hold) begin
            r_s1_read   <= is_read;
            r_s1_hist   <= is_read && idx_hist;
            r_s1_bump   <= hist_bump;
            r_s1_addr   <= rd_addr;
            r_s1_scalar <= scalar_val;
        end
    end

    // Output register
    logic s1_out;
    assign s1_out = r_s1_valid && r_s1_read && !s1_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_out) begin
            r_out_value <= r_s1_hist ? sgm_pkg::STAT_BITS'(cur_bin) : r_s1_scalar;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_stat_value = r_out_value;

    // Checks
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && r_s1_valid && r_s1_read))
        else $error("input stalled without a waiting read result");

    a_wr_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_s1_addr <= sgm_pkg::BIN_LAST))
        else $error("histogram write outside bin range");

    a_back_eq_disorder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_back_jump_count == r_disorder_count)
        else $error("back jump and disorder counts diverged");

    a_first_sets_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_req && !r_seen_any) |=> (r_seen_any && (r_first_seq == r_prev_seq)))
        else $error("first request not recorded");

    a_write_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_bin_valid[$past(r_s1_addr)])
        else $error("written bin not marked valid");

endmodule

`default_nettype wire
